FILE: rtl/core/qrs_pkg.sv
// shared constants and types for the quadratic root solver
// no dependencies
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int DISC_OUT_W     = 34;
  localparam int ROOT_OUT_W     = 40;
  localparam int FRAC_BITS      = 16;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_AZERO = 2'd3
  } status_e;

endpackage

FILE: rtl/core/qrs_if.sv
// channel interfaces for the quadratic root solver
// depends on qrs_pkg
interface qrs_coef_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;
  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_res_if;
  import qrs_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   root_status;
  logic signed [DISC_OUT_W-1:0] discriminant;
  logic signed [ROOT_OUT_W-1:0] root_plus;
  logic signed [ROOT_OUT_W-1:0] root_minus;
  modport source (output valid, root_status, discriminant, root_plus, root_minus,
                  input ready);
  modport sink   (input valid, root_status, discriminant, root_plus, root_minus,
                  output ready);
endinterface

FILE: rtl/core/quadratic_root_solver.sv
// top level of the quadratic root solver: discriminant, square root and
// divider pipelines; depends on qrs_pkg, qrs_if, qrs_disc, qrs_sqrt, qrs_div
//
// Solves a*x^2 + b*x + c = 0 for signed Q8.8 coefficients. Each item yields
// one result: the exact Q18.16 discriminant, a status (no real root, one root,
// two roots, a is zero) and the Q24.16 roots truncated toward zero, zeros where
// a root is absent. The pipeline takes one item per clock and holds a single
// stall enable, so when the output side is ready an item enters every cycle.
// Stages in order: a products stage and a discriminant stage, COEF_WIDTH+1
// square root stages (one root bit each), one numerator stage, COEF_WIDTH+18
// divider stages (one quotient bit each) and the output register.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  qrs_coef_if.sink  coef_i,
  qrs_res_if.source res_o
);
  import qrs_pkg::*;

  localparam int W      = COEF_WIDTH;
  localparam int DW     = 2*W + 2;        // discriminant width
  localparam int SW     = W + 1;          // square root width
  localparam int NW     = W + 3;          // signed numerator width
  localparam int NUMW   = W + 2;          // numerator magnitude width
  localparam int DENW   = W + 1;          // |2a| width
  localparam int QW     = NUMW + FRAC_BITS;
  localparam int SIDE1  = 2 + DW + 2*W;   // status, disc, a, b
  localparam int SIDE2  = 2 + DW + 2;     // status, disc, sign of each root

  // single stall enable: everything moves when the output slot frees up
  logic adv;
  logic out_vld_q;
  assign adv          = !out_vld_q || res_o.ready;
  assign coef_i.ready = adv;

  // discriminant stages
  logic                 d_vld;
  logic signed [DW-1:0] d_disc;
  status_e              d_status;
  logic signed [W-1:0]  d_a, d_b;

  qrs_disc #(.W(W)) u_disc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (coef_i.valid),
    .a_i      (coef_i.coef_a),
    .b_i      (coef_i.coef_b),
    .c_i      (coef_i.coef_c),
    .vld_o    (d_vld),
    .disc_o   (d_disc),
    .status_o (d_status),
    .a_o      (d_a),
    .b_o      (d_b)
  );

  // square root of the discriminant; negative values give junk that the
  // status masks later
  logic             s_vld;
  logic [SW-1:0]    s_root;
  logic [SIDE1-1:0] s_side;

  qrs_sqrt #(.SW(SW), .SIDE_W(SIDE1)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (d_vld),
    .rad_i  (d_disc),
    .side_i ({d_status, d_disc, d_a, d_b}),
    .vld_o  (s_vld),
    .root_o (s_root),
    .side_o (s_side)
  );

  // numerator stage: -b +/- s and |2a|, signs kept for the divider output
  logic [1:0]           s_status;
  logic signed [DW-1:0] s_disc;
  logic signed [W-1:0]  s_a, s_b;
  assign {s_status, s_disc, s_a, s_b} = s_side;

  logic signed [NW-1:0] negb, root_sx, num_p, num_m;
  logic signed [W:0]    den2;
  logic [NUMW-1:0]      mag_p, mag_m;
  logic [DENW-1:0]      mag_den;

  always_comb begin
    negb    = -NW'(s_b);
    root_sx = signed'(NW'(s_root));
    num_p   = negb + root_sx;
    num_m   = negb - root_sx;
    den2    = {s_a, 1'b0};
    mag_p   = num_p[NW-1] ? NUMW'(-num_p) : NUMW'(num_p);
    mag_m   = num_m[NW-1] ? NUMW'(-num_m) : NUMW'(num_m);
    mag_den = den2[W] ? DENW'(-den2) : DENW'(den2);
  end

  logic                 n_vld_q;
  logic [1:0][NUMW-1:0] n_num_q;
  logic [DENW-1:0]      n_den_q;
  logic [SIDE2-1:0]     n_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else if (adv) begin
      n_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_num_q  <= {mag_m, mag_p};
      n_den_q  <= mag_den;
      n_side_q <= {s_status, s_disc, num_p[NW-1] ^ s_a[W-1], num_m[NW-1] ^ s_a[W-1]};
    end
  end

  // both quotients share the divisor |2a|
  logic               q_vld;
  logic [1:0][QW-1:0] q_quo;
  logic [SIDE2-1:0]   q_side;

  qrs_div #(.NUMW(NUMW), .DENW(DENW), .FRAC(FRAC_BITS), .SIDE_W(SIDE2)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (n_vld_q),
    .num_i  (n_num_q),
    .den_i  (n_den_q),
    .side_i (n_side_q),
    .vld_o  (q_vld),
    .quo_o  (q_quo),
    .side_o (q_side)
  );

  // apply signs, pick by status, fit to the output widths
  logic [1:0]           q_status;
  logic signed [DW-1:0] q_disc;
  logic                 q_neg_p, q_neg_m;
  assign {q_status, q_disc, q_neg_p, q_neg_m} = q_side;

  logic signed [QW:0] rq_p, rq_m;
  logic signed [63:0] wide_p, wide_m, wide_d;
  logic [ROOT_OUT_W-1:0] root_p_d, root_m_d;

  always_comb begin
    rq_p   = signed'({1'b0, q_quo[0]});
    rq_m   = signed'({1'b0, q_quo[1]});
    wide_p = 64'(q_neg_p ? -rq_p : rq_p);
    wide_m = 64'(q_neg_m ? -rq_m : rq_m);
    wide_d = 64'(q_disc);
    root_p_d = '0;
    root_m_d = '0;
    case (status_e'(q_status))
      ST_ONE: begin
        root_p_d = wide_p[ROOT_OUT_W-1:0];
      end
      ST_TWO: begin
        root_p_d = wide_p[ROOT_OUT_W-1:0];
        root_m_d = wide_m[ROOT_OUT_W-1:0];
      end
      default: begin
        root_p_d = '0;
        root_m_d = '0;
      end
    endcase
  end

  // output register
  logic [1:0]            out_status_q;
  logic [DISC_OUT_W-1:0] out_disc_q;
  logic [ROOT_OUT_W-1:0] out_rp_q, out_rm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= q_status;
      out_disc_q   <= wide_d[DISC_OUT_W-1:0];
      out_rp_q     <= root_p_d;
      out_rm_q     <= root_m_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.root_status  = out_status_q;
  assign res_o.discriminant = signed'(out_disc_q);
  assign res_o.root_plus    = signed'(out_rp_q);
  assign res_o.root_minus   = signed'(out_rm_q);

endmodule

FILE: rtl/core/qrs_disc.sv
// two-stage discriminant unit: products, then b*b - 4ac and classification
// depends on qrs_pkg
module qrs_disc #(
  parameter int W = qrs_pkg::COEF_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  input  logic signed [W-1:0]   c_i,
  output logic                  vld_o,
  output logic signed [2*W+1:0] disc_o,
  output qrs_pkg::status_e      status_o,
  output logic signed [W-1:0]   a_o,
  output logic signed [W-1:0]   b_o
);
  import qrs_pkg::*;

  logic                  v1_q, v2_q;
  logic signed [2*W-1:0] bb_q, ac_q;
  logic signed [W-1:0]   a1_q, b1_q, a2_q, b2_q;
  logic signed [2*W+1:0] disc_d, disc_q;
  status_e               status_d, status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bb_q <= b_i * b_i;
      ac_q <= a_i * c_i;
      a1_q <= a_i;
      b1_q <= b_i;
    end
  end

  always_comb begin
    disc_d = (2*W+2)'(bb_q) - ((2*W+2)'(ac_q) <<< 2);
    if (a1_q == '0) begin
      status_d = ST_AZERO;
    end else if (disc_d[2*W+1]) begin
      status_d = ST_NONE;
    end else if (disc_d == '0) begin
      status_d = ST_ONE;
    end else begin
      status_d = ST_TWO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      disc_q   <= disc_d;
      status_q <= status_d;
      a2_q     <= a1_q;
      b2_q     <= b1_q;
    end
  end

  assign vld_o    = v2_q;
  assign disc_o   = disc_q;
  assign status_o = status_q;
  assign a_o      = a2_q;
  assign b_o      = b2_q;

endmodule

FILE: rtl/core/qrs_sqrt.sv
// pipelined restoring integer square root, one result bit per stage
// depends on qrs_pkg
module qrs_sqrt #(
  parameter int SW     = qrs_pkg::COEF_WIDTH_DEF + 1,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [2*SW-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [SW-1:0]     root_o,
  output logic [SIDE_W-1:0] side_o
);
  import qrs_pkg::*;

  logic              vld_q  [SW];
  logic [2*SW-1:0]   rad_q  [SW];
  logic [SW+1:0]     rem_q  [SW];
  logic [SW-1:0]     rt_q   [SW];
  logic [SIDE_W-1:0] side_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic              v_in;
    logic [2*SW-1:0]   rad_in;
    logic [SW+1:0]     rem_in;
    logic [SW-1:0]     rt_in;
    logic [SIDE_W-1:0] side_in;
    logic [SW+1:0]     shifted;
    logic [SW+1:0]     trial;

    if (k == 0) begin : g_first
      assign v_in    = vld_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign rt_in   = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign rt_in   = rt_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign shifted = {rem_in[SW-1:0], rad_in[2*SW-1 -: 2]};
    assign trial   = {rt_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        side_q[k] <= side_in;
        if (shifted >= trial) begin
          rem_q[k] <= shifted - trial;
          rt_q[k]  <= {rt_in[SW-2:0], 1'b1};
        end else begin
          rem_q[k] <= shifted;
          rt_q[k]  <= {rt_in[SW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_q[SW-1];
  assign root_o = rt_q[SW-1];
  assign side_o = side_q[SW-1];

endmodule

FILE: rtl/core/qrs_div.sv
// two-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage; depends on qrs_pkg
module qrs_div #(
  parameter int NUMW   = qrs_pkg::COEF_WIDTH_DEF + 2,
  parameter int DENW   = qrs_pkg::COEF_WIDTH_DEF + 1,
  parameter int FRAC   = qrs_pkg::FRAC_BITS,
  parameter int SIDE_W = 1,
  localparam int QW    = NUMW + FRAC
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [1:0][NUMW-1:0] num_i,
  input  logic [DENW-1:0]      den_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic [1:0][QW-1:0]   quo_o,
  output logic [SIDE_W-1:0]    side_o
);
  import qrs_pkg::*;

  logic                vld_q  [QW];
  logic [1:0][QW-1:0]  dvd_q  [QW];
  logic [1:0][DENW-1:0] rem_q [QW];
  logic [DENW-1:0]     den_q  [QW];
  logic [SIDE_W-1:0]   side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                 v_in;
    logic [1:0][QW-1:0]   dvd_in;
    logic [1:0][DENW-1:0] rem_in;
    logic [DENW-1:0]      den_in;
    logic [SIDE_W-1:0]    side_in;
    logic [1:0][QW-1:0]   dvd_d;
    logic [1:0][DENW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign v_in      = vld_i;
      assign dvd_in[0] = {num_i[0], {FRAC{1'b0}}};
      assign dvd_in[1] = {num_i[1], {FRAC{1'b0}}};
      assign rem_in    = '0;
      assign den_in    = den_i;
      assign side_in   = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign dvd_in  = dvd_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // quotient bits shift into the low end of the dividend register
    always_comb begin
      logic [DENW:0] sh;
      logic          ge;
      for (int l = 0; l < 2; l++) begin
        sh       = {rem_in[l], dvd_in[l][QW-1]};
        ge       = (sh >= {1'b0, den_in});
        rem_d[l] = ge ? DENW'(sh - {1'b0, den_in}) : sh[DENW-1:0];
        dvd_d[l] = {dvd_in[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dvd_q[k]  <= dvd_d;
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quo_o  = dvd_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

FILE: dv/qrs_checker.sv
`timescale 1ns / 1ps
// checker for the quadratic root solver: watches both channels, predicts
// each result and compares it field by field; depends on qrs_pkg
module qrs_checker
  import qrs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_ready_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  input  logic signed [15:0] c_i,
  input  logic    out_valid_i,
  input  logic    out_ready_i,
  input  logic [1:0] status_i,
  input  logic signed [DISC_OUT_W-1:0] disc_i,
  input  logic signed [ROOT_OUT_W-1:0] rp_i,
  input  logic signed [ROOT_OUT_W-1:0] rm_i,
  output int      errors_o,
  output int      pending_o,
  output int      seen_o,
  output int      two_roots_o,
  output int      one_root_o,
  output int      no_root_o,
  output int      a_zero_o
);

  typedef struct packed {
    status_e                      status;
    logic signed [DISC_OUT_W-1:0] disc;
    logic signed [ROOT_OUT_W-1:0] rp;
    logic signed [ROOT_OUT_W-1:0] rm;
  } roots_t;

  roots_t root_q[$];

  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    for (int k = 17; k >= 0; k--) begin
      if ((r + (longint'(1) << k)) * (r + (longint'(1) << k)) <= v)
        r = r + (longint'(1) << k);
    end
    return r;
  endfunction

  function automatic longint quot_q16(longint num, longint den);
    longint n, d, q;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = (n * 65536) / d;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic roots_t solve_roots(longint a, longint b, longint c);
    roots_t r;
    longint d, s, rp, rm;
    d  = b * b - 4 * a * c;
    rp = 0;
    rm = 0;
    if (a == 0) r.status = ST_AZERO;
    else if (d < 0) r.status = ST_NONE;
    else if (d == 0) begin
      r.status = ST_ONE;
      rp = quot_q16(-b, 2 * a);
    end else begin
      s = floor_sqrt(d);
      r.status = ST_TWO;
      rp = quot_q16(-b + s, 2 * a);
      rm = quot_q16(-b - s, 2 * a);
    end
    r.disc = d[DISC_OUT_W-1:0];
    r.rp   = rp[ROOT_OUT_W-1:0];
    r.rm   = rm[ROOT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d want %0d", seen_o, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0; seen_o = 0;
    two_roots_o = 0; one_root_o = 0; no_root_o = 0; a_zero_o = 0;
  end

  assign pending_o = root_q.size();

  always @(posedge clk_i) begin
    roots_t want;
    if (rst_ni && in_valid_i && in_ready_i)
      root_q.push_back(solve_roots(a_i, b_i, c_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (root_q.size() == 0) begin
        $display("result with no item waiting");
        errors_o++;
      end else begin
        want = root_q.pop_front();
        case (want.status)
          ST_TWO:  two_roots_o++;
          ST_ONE:  one_root_o++;
          ST_NONE: no_root_o++;
          default: a_zero_o++;
        endcase
        if (status_i !== want.status) report_mismatch("status", status_i, want.status);
        if (disc_i !== want.disc) report_mismatch("discriminant", disc_i, want.disc);
        if (rp_i !== want.rp) report_mismatch("root_plus", rp_i, want.rp);
        if (rm_i !== want.rm) report_mismatch("root_minus", rm_i, want.rm);
      end
      seen_o++;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// top of the quadratic root solver testbench: clock, reset, coefficient
// stimulus and verdict; depends on qrs_pkg, qrs_if, qrs_checker and the block
module tb;
  import qrs_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int LATENCY      = 2 * COEF_WIDTH_DEF + 23;

  logic clk_i;
  logic rst_ni;
  int   errors, pending, seen, n_two, n_one, n_none, n_azero;
  int   sent;
  bit   long_hold;  // receiver forced off for the backpressure test

  qrs_coef_if #(16) coef_ch ();
  qrs_res_if        res_ch ();

  quadratic_root_solver uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef_ch.sink),
    .res_o  (res_ch.source)
  );

  qrs_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (coef_ch.valid),
    .in_ready_i  (coef_ch.ready),
    .a_i         (coef_ch.coef_a),
    .b_i         (coef_ch.coef_b),
    .c_i         (coef_ch.coef_c),
    .out_valid_i (res_ch.valid),
    .out_ready_i (res_ch.ready),
    .status_i    (res_ch.root_status),
    .disc_i      (res_ch.discriminant),
    .rp_i        (res_ch.root_plus),
    .rm_i        (res_ch.root_minus),
    .errors_o    (errors),
    .pending_o   (pending),
    .seen_o      (seen),
    .two_roots_o (n_two),
    .one_root_o  (n_one),
    .no_root_o   (n_none),
    .a_zero_o    (n_azero)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // coefficient sets that hit the corners: a zero, extremes of every field,
  // a zero discriminant, a negative one, and roots of both signs
  typedef logic signed [15:0] coef_t;
  coef_t dir_a[$] = '{16'sd0, 16'sd0, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                      16'sd256, 16'sd256, 16'sd256, -16'sd256, 16'sd256, 16'sd1,
                      -16'sd1, 16'sd512, 16'sd256, 16'sd256, -16'sd32768, 16'sd1,
                      16'sd256, -16'sd1};
  coef_t dir_b[$] = '{16'sd0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                      -16'sd512, 16'sd0, 16'sd0, 16'sd512, 16'sd768, 16'sd0,
                      -16'sd1, 16'sd1024, -16'sd1, 16'sd32767, 16'sd0, 16'sd2,
                      16'sd512, -16'sd1};
  coef_t dir_c[$] = '{16'sd0, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                      16'sd256, 16'sd256, -16'sd256, -16'sd256, 16'sd512, 16'sd0,
                      16'sd0, 16'sd512, 16'sd0, -16'sd32768, 16'sd32767, 16'sd1,
                      16'sd256, -16'sd1};

  // draws a set: mostly real roots, some with a zero discriminant, some with a = 0, some small, some raw
  task automatic pick_coefs(output coef_t a, output coef_t b, output coef_t c);
    int kind;
    int r1, r2, k;
    kind = $urandom_range(0, 9);
    a = coef_t'($urandom);
    b = coef_t'($urandom);
    c = coef_t'($urandom);
    if (kind < 3) begin
      // double root: a*(x-r)^2 gives b = -2ar, c = a*r*r, all exact in Q8.8
      k  = $urandom_range(1, 2) * (($urandom & 1) ? 1 : -1);
      r1 = $signed($urandom_range(0, 14)) - 7;
      a  = coef_t'(k * 256);
      b  = coef_t'(-2 * k * r1 * 256);
      c  = coef_t'(k * r1 * r1 * 256);
    end else if (kind < 6) begin
      // two integer roots
      k  = ($urandom & 1) ? 1 : -1;
      r1 = $signed($urandom_range(0, 20)) - 10;
      r2 = $signed($urandom_range(0, 20)) - 10;
      a  = coef_t'(k * 256);
      b  = coef_t'(-k * (r1 + r2) * 256);
      c  = coef_t'(k * r1 * r2 * 256);
    end else if (kind == 6) begin
      a = 16'sd0;
    end else if (kind == 7) begin
      a = coef_t'($signed($urandom_range(0, 64)) - 32);
      b = coef_t'($signed($urandom_range(0, 64)) - 32);
      c = coef_t'($signed($urandom_range(0, 64)) - 32);
    end
  endtask

  task automatic send_set(coef_t a, coef_t b, coef_t c);
    coef_ch.valid  <= 1'b1;
    coef_ch.coef_a <= a;
    coef_ch.coef_b <= b;
    coef_ch.coef_c <= c;
    @(posedge clk_i);
    while (!coef_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // sender: bursts of items separated by random gaps
  initial begin
    coef_t a, b, c;
    int burst;
    coef_ch.valid  = 1'b0;
    coef_ch.coef_a = '0;
    coef_ch.coef_b = '0;
    coef_ch.coef_c = '0;
    sent   = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_a[i]) send_set(dir_a[i], dir_b[i], dir_c[i]);
    while (sent < dir_a.size() + RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) begin
        pick_coefs(a, b, c);
        send_set(a, b, c);
      end
      if ($urandom_range(0, 2) != 0) begin
        coef_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    coef_ch.valid <= 1'b0;
    // drain, then let any trailing result surface
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("covered %0d items: %0d two-root, %0d one-root, %0d no-root, %0d a-zero",
             seen, n_two, n_one, n_none, n_azero);
    $display("with input bursts, output stalls and a long output hold-off");
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // long output hold-off once the pipe is busy, so the input has to stall
  initial begin
    long_hold = 1'b0;
    wait (sent >= 60);
    long_hold = 1'b1;
    repeat (3 * LATENCY) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // receiver: stretches of full speed and stretches of random stalls
  initial begin
    int mode;
    res_ch.ready = 1'b0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
      if (long_hold) res_ch.ready <= 1'b0;
      else if (mode == 0) res_ch.ready <= 1'b1;
      else if (mode == 1) res_ch.ready <= ($urandom_range(0, 3) != 0);
      else res_ch.ready <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
